@@ rtl/core/spm_pkg.sv @@
// Shared types, constants and helpers for the substring presence matcher.
// No dependencies; every other file in rtl/core refers to it by scoped name.
`default_nettype none

package spm_pkg;

   localparam int DATA_W        = 64;
   localparam int ADDR_W        = 5;
   localparam int BYTE_W        = 8;
   localparam int PATTERN_SLOTS = 16;
   localparam int LENGTH_W      = 5;

   localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
   localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
   localparam logic [1:0] REG_PATTERN_LEN  = 2'd2;
   localparam logic [1:0] REG_IGNORE_CASE  = 2'd3;

   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = CHAR_LOWER_A - CHAR_UPPER_A;
   localparam logic [BYTE_W-1:0] TEXT_END     = 8'h00;

   typedef struct packed {
      logic [DATA_W-1:0]   pattern_low;
      logic [DATA_W-1:0]   pattern_high;
      logic [LENGTH_W-1:0] pattern_length;
      logic                ignore_case;
   } cfg_type;

   function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                   input logic ic);
      logic [BYTE_W-1:0] r;
      r = b;
      if (ic && (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) begin
         r = b + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/spm_ifs.sv @@
// Valid/ready channel interfaces for text bytes in and match results out.
// Depends on spm_pkg for the byte width.
`default_nettype none

interface spm_req_if;
   logic                      valid;
   logic                      ready;
   logic [spm_pkg::BYTE_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface spm_rsp_if;
   logic valid;
   logic ready;
   logic found;

   modport source (output valid, output found, input ready);
   modport sink (input valid, input found, output ready);
endinterface

`default_nettype wire

@@ rtl/core/spm_csr.sv @@
// APB-style register file: pattern words, pattern length and case mode.
// Depends on spm_pkg for widths, register indexes and cfg_type.
`default_nettype none

module spm_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [spm_pkg::ADDR_W-1:0] paddr,
   input  wire logic [spm_pkg::DATA_W-1:0] pwdata,
   output logic      [spm_pkg::DATA_W-1:0] prdata,
   output logic                            pready,
   output spm_pkg::cfg_type                cfg
);

   logic [spm_pkg::DATA_W-1:0]   pat_low_ff, pat_low_in;
   logic [spm_pkg::DATA_W-1:0]   pat_high_ff, pat_high_in;
   logic [spm_pkg::LENGTH_W-1:0] pat_len_ff, pat_len_in;
   logic                         icase_ff, icase_in;
   logic                         wr_en;
   logic [1:0]                   reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[spm_pkg::ADDR_W-1:3];

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      pat_len_in  = pat_len_ff;
      icase_in    = icase_ff;
      if (wr_en) begin
         case (reg_idx)
            spm_pkg::REG_PATTERN_LOW:  pat_low_in  = pwdata;
            spm_pkg::REG_PATTERN_HIGH: pat_high_in = pwdata;
            spm_pkg::REG_PATTERN_LEN:  pat_len_in  = pwdata[spm_pkg::LENGTH_W-1:0];
            spm_pkg::REG_IGNORE_CASE:  icase_in    = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
         icase_ff    <= 1'b0;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         pat_len_ff  <= pat_len_in;
         icase_ff    <= icase_in;
      end
   end

   always_comb begin
      case (reg_idx)
         spm_pkg::REG_PATTERN_LOW:  prdata = pat_low_ff;
         spm_pkg::REG_PATTERN_HIGH: prdata = pat_high_ff;
         spm_pkg::REG_PATTERN_LEN:  prdata = spm_pkg::DATA_W'(pat_len_ff);
         spm_pkg::REG_IGNORE_CASE:  prdata = spm_pkg::DATA_W'(icase_ff);
         default:                   prdata = '0;
      endcase
   end

   assign cfg.pattern_low    = pat_low_ff;
   assign cfg.pattern_high   = pat_high_ff;
   assign cfg.pattern_length = pat_len_ff;
   assign cfg.ignore_case    = icase_ff;

endmodule

`default_nettype wire

@@ rtl/core/spm_window.sv @@
// Recent-byte window, valid count and sticky match flag; parallel compare per byte.
// Depends on spm_pkg for cfg_type, fold_byte and the text terminator.
`default_nettype none

module spm_window #(
   parameter int NEEDLE_MAX = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic [spm_pkg::BYTE_W-1:0] text_byte,
   input  wire spm_pkg::cfg_type           cfg,
   output logic                            found
);

   localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
   localparam int IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

   logic [spm_pkg::BYTE_W-1:0] win_ff [NEEDLE_MAX];
   logic [spm_pkg::BYTE_W-1:0] win_in [NEEDLE_MAX];
   logic [spm_pkg::BYTE_W-1:0] win_shift [NEEDLE_MAX];
   logic [LEN_W-1:0]           count_ff, count_in, count_shift;
   logic                       seen_ff, seen_in;
   logic [LEN_W-1:0]           eff_len;
   logic                       is_end;
   logic                       all_eq;
   logic [spm_pkg::PATTERN_SLOTS-1:0][spm_pkg::BYTE_W-1:0] pat_bytes;

   assign pat_bytes = {cfg.pattern_high, cfg.pattern_low};
   assign eff_len = (cfg.pattern_length > spm_pkg::LENGTH_W'(NEEDLE_MAX)) ?
                    LEN_W'(NEEDLE_MAX) : LEN_W'(cfg.pattern_length);
   assign is_end = (text_byte == spm_pkg::TEXT_END);

   always_comb begin
      win_shift[0] = text_byte;
      for (int i = 1; i < NEEDLE_MAX; i++) begin
         win_shift[i] = win_ff[i-1];
      end
      count_shift = (count_ff < LEN_W'(NEEDLE_MAX)) ? count_ff + LEN_W'(1) : count_ff;
   end

   always_comb begin
      logic [LEN_W-1:0]           idx;
      logic [spm_pkg::BYTE_W-1:0] tb;
      all_eq = 1'b1;
      for (int k = 0; k < NEEDLE_MAX; k++) begin
         idx = eff_len - LEN_W'(1) - LEN_W'(k);
         tb  = win_shift[idx[IDX_W-1:0]];
         if ((LEN_W'(k) < eff_len) &&
             (spm_pkg::fold_byte(tb, cfg.ignore_case) !=
              spm_pkg::fold_byte(pat_bytes[k], cfg.ignore_case))) begin
            all_eq = 1'b0;
         end
      end
   end

   always_comb begin
      win_in   = win_ff;
      count_in = count_ff;
      seen_in  = seen_ff;
      if (advance) begin
         if (is_end) begin
            for (int i = 0; i < NEEDLE_MAX; i++) begin
               win_in[i] = '0;
            end
            count_in = '0;
            seen_in  = 1'b0;
         end else begin
            win_in   = win_shift;
            count_in = count_shift;
            if ((eff_len != '0) && (count_shift >= eff_len) && all_eq) begin
               seen_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seen_ff  <= 1'b0;
         for (int i = 0; i < NEEDLE_MAX; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         seen_ff  <= seen_in;
         win_ff   <= win_in;
      end
   end

   assign found = (eff_len == '0) || seen_ff;

endmodule

`default_nettype wire

@@ rtl/core/substring_presence_matcher_top.sv @@
// Substring presence matcher: text bytes in, one found flag per text out.
// Depends on spm_pkg, spm_ifs, spm_csr and spm_window.
//
// Usage:
//   req_bus carries one text byte per beat; a zero byte ends the text.
//   rsp_bus carries one found beat for each zero byte, none for other bytes.
//   The APB-style port holds the pattern (two 64-bit words at 0x00 and 0x08),
//   the pattern length at 0x10 and the case-fold mode at 0x18; write it only
//   while no text is in flight.
// Throughput: one byte per cycle while not stalled; all window compares run in
//   parallel in the single stage from the input register to the match flag.
// Output: a zero byte's found beat is registered in the result register.
// Stall: while a result waits on rsp_bus, non-terminator bytes keep flowing;
//   a further zero byte holds in the input register and req_bus ready drops.
// Reset: synchronous, active high; clears the registers, the window, the
//   valid count, the match flag and the valid bits of both pipeline registers.
`default_nettype none

module substring_presence_matcher_top #(
   parameter int NEEDLE_MAX = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   spm_req_if.sink                         req_bus,
   spm_rsp_if.source                       rsp_bus,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [spm_pkg::ADDR_W-1:0] paddr,
   input  wire logic [spm_pkg::DATA_W-1:0] pwdata,
   output logic      [spm_pkg::DATA_W-1:0] prdata,
   output logic                            pready
);

   spm_pkg::cfg_type           cfg;
   logic                       s1_valid_ff, s1_valid_in;
   logic [spm_pkg::BYTE_W-1:0] s1_byte_ff, s1_byte_in;
   logic                       out_valid_ff, out_valid_in;
   logic                       out_found_ff, out_found_in;
   logic                       s1_is_end;
   logic                       out_free;
   logic                       s1_go;
   logic                       win_found;

   spm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   spm_window #(
      .NEEDLE_MAX (NEEDLE_MAX)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_go),
      .text_byte (s1_byte_ff),
      .cfg       (cfg),
      .found     (win_found)
   );

   assign s1_is_end = (s1_byte_ff == spm_pkg::TEXT_END);
   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign s1_go     = s1_valid_ff && (!s1_is_end || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_go;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_byte_in   = s1_byte_ff;
      out_valid_in = out_valid_ff;
      out_found_in = out_found_ff;
      if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      if (req_bus.valid && req_bus.ready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_bus.text_byte;
      end
      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (s1_go && s1_is_end) begin
         out_valid_in = 1'b1;
         out_found_in = win_found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff   <= s1_byte_in;
      out_found_ff <= out_found_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.found = out_found_ff;

endmodule

`default_nettype wire
